// ===== hdl/modbus_rtu_frame_checker_defines.svh =====
// Assertion macros for the frame checker's property module.
// Relies on the asserting module having ports i_clk and i_rst_n.
`ifndef MODBUS_RTU_FRAME_CHECKER_DEFINES_SVH
`define MODBUS_RTU_FRAME_CHECKER_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define MRFC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define MRFC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mrfc_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the Modbus RTU frame checker.
// No dependencies.
package mrfc_pkg;

    localparam int unsigned MAX_FRAME_DEF = 256;
    localparam int unsigned LEN_W         = 9;
    localparam int unsigned DATA_W        = 8;
    localparam int unsigned CRC_W         = 16;
    localparam int unsigned RES_W         = 40;

    localparam logic [CRC_W-1:0]  CRC_INIT     = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY     = 16'hA001;
    localparam logic [LEN_W-1:0]  MIN_FRAME    = 9'd6;
    localparam logic [DATA_W-1:0] SLAVE_ID_RST = 8'd1;
    localparam logic [DATA_W-1:0] ADDR_BCAST   = 8'd0;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic [2:0]        pad;
        logic [CRC_W-1:0]  computed_crc;
        logic              overlong;
        logic [LEN_W-1:0]  frame_length;
        logic [DATA_W-1:0] function_code;
        logic              broadcast;
        logic              addressed;
        logic              frame_valid;
    } t_result;

    // Reflected CRC-16 update with one byte, bit by bit
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [DATA_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-DATA_W){1'b0}}, b};
        for (int k = 0; k < DATA_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/modbus_rtu_frame_checker.sv =====
// Modbus RTU frame checker: one byte per cycle, CRC-16 over all but the last two bytes.
// The result request is registered and appears in the cycle after the last byte is accepted.
// Throughput: one byte per cycle; the byte-wide CRC update sits between state registers.
// Input stalls only while a finished result waits and the output side is not ready.
// Reset (synchronous, active low) clears frame state, empties the output and sets slave_id to 1.
module modbus_rtu_frame_checker #(
    parameter int unsigned MAX_FRAME = mrfc_pkg::MAX_FRAME_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // data_byte
    input  logic [mrfc_pkg::DATA_W-1:0] i_s_tdata,
    input  logic                        i_s_tlast,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // frame_valid, addressed, broadcast, function_code[7:0], frame_length[8:0],
    // overlong, computed_crc[15:0], zero pad[2:0]
    output logic [mrfc_pkg::RES_W-1:0]  o_m_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // slave_id
    input  logic [mrfc_pkg::DATA_W-1:0] i_cfg_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready
);
    import mrfc_pkg::*;

    logic [DATA_W-1:0] r_slave_id;
    logic              in_accept;
    t_result           result_n;
    t_result           result_q;

    assign in_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = result_q;

    // Own station address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_id <= SLAVE_ID_RST;
        end else if (i_cfg_valid) begin
            r_slave_id <= i_cfg_data;
        end
    end

    mrfc_frame_state #(
        .MAX_FRAME (MAX_FRAME)
    ) u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_data     (i_s_tdata),
        .i_last     (i_s_tlast),
        .i_slave_id (r_slave_id),
        .o_result   (result_n)
    );

    mrfc_result_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_accept && i_s_tlast),
        .i_result   (result_n),
        .i_m_tready (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_open     (o_s_tready),
        .o_result   (result_q)
    );

endmodule

// ===== hdl/mrfc_frame_state.sv =====
// Per-frame state: running CRC, two-byte hold-back line, byte count, address and function.
// Depends on mrfc_pkg.
module mrfc_frame_state #(
    parameter int unsigned MAX_FRAME = mrfc_pkg::MAX_FRAME_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [mrfc_pkg::DATA_W-1:0] i_data,
    input  logic                       i_last,
    input  logic [mrfc_pkg::DATA_W-1:0] i_slave_id,
    output mrfc_pkg::t_result          o_result
);
    import mrfc_pkg::*;

    logic [CRC_W-1:0]  r_crc,  n_crc;
    logic [DATA_W-1:0] r_dly0, r_dly1;
    logic [LEN_W-1:0]  r_count, n_count;
    logic [DATA_W-1:0] r_addr, n_addr;
    logic [DATA_W-1:0] r_func, n_func;
    logic              r_ovf,  n_ovf;
    logic [CRC_W-1:0]  received;
    logic              full;
    logic              valid;
    logic              bcast;

    // Next state for one byte
    always_comb begin
        full     = r_count >= LEN_W'(MAX_FRAME);
        n_crc    = (r_count >= LEN_W'(2)) ? crc_feed(r_crc, r_dly1) : r_crc;
        n_addr   = (r_count == '0) ? i_data : r_addr;
        n_func   = (r_count == LEN_W'(1)) ? i_data : r_func;
        n_ovf    = r_ovf | full;
        n_count  = full ? r_count : r_count + LEN_W'(1);
        // received CRC travels low byte first
        received = {i_data, r_dly0};
        valid    = (n_count >= MIN_FRAME) && !n_ovf && (received == n_crc);
        bcast    = n_addr == ADDR_BCAST;

        o_result.pad           = '0;
        o_result.computed_crc  = n_crc;
        o_result.overlong      = n_ovf;
        o_result.frame_length  = n_count;
        o_result.function_code = n_func;
        o_result.broadcast     = bcast;
        o_result.addressed     = valid && (bcast || n_addr == i_slave_id);
        o_result.frame_valid   = valid;
    end

    // Advance on each byte, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_crc   <= CRC_INIT;
            r_dly0  <= '0;
            r_dly1  <= '0;
            r_count <= '0;
            r_addr  <= '0;
            r_func  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            r_crc   <= n_crc;
            r_dly1  <= r_dly0;
            r_dly0  <= i_data;
            r_count <= n_count;
            r_addr  <= n_addr;
            r_func  <= n_func;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// ===== hdl/mrfc_result_reg.sv =====
// Output register for one frame result with its valid flag and the upstream ready.
// Depends on mrfc_pkg.
module mrfc_result_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mrfc_pkg::t_result i_result,
    input  logic              i_m_tready,
    output logic              o_valid,
    output logic              o_open,
    output mrfc_pkg::t_result o_result
);
    import mrfc_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Room for a new result when empty or being drained this cycle
    assign o_open   = !r_valid || i_m_tready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Hold the request until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_open) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_open && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== hdl/mrfc_checker.sv =====
// Port-level properties of the frame checker, bound to the top level.
// Depends on mrfc_pkg and modbus_rtu_frame_checker_defines.svh.
`include "modbus_rtu_frame_checker_defines.svh"

module mrfc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tlast,
    input  logic                        i_s_tvalid,
    input  logic                        o_s_tready,
    input  logic [mrfc_pkg::RES_W-1:0]  o_m_tdata,
    input  logic                        o_m_tvalid,
    input  logic                        i_m_tready
);
    import mrfc_pkg::*;

    t_result res;
    logic    in_acc;
    logic    out_acc;

    assign res     = o_m_tdata;
    assign in_acc  = i_s_tvalid && o_s_tready;
    assign out_acc = o_m_tvalid && i_m_tready;

    // A stalled result holds its request and payload
    `MRFC_ASSERT_NXT(a_out_hold, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata), "stalled result changed")
    // An empty output never blocks input
    `MRFC_ASSERT_IMP(a_ready_when_empty, !o_m_tvalid, o_s_tready,
        "input blocked while output empty")
    // A last byte always yields a result next cycle
    `MRFC_ASSERT_NXT(a_last_gives_result, in_acc && i_s_tlast, o_m_tvalid,
        "no result after last byte")
    // A mid-frame byte yields no result once the output has drained
    `MRFC_ASSERT_NXT(a_no_spurious, in_acc && !i_s_tlast && (out_acc || !o_m_tvalid),
        !o_m_tvalid, "result without last byte")
    // Valid and addressed need a full-length, non-overlong frame
    `MRFC_ASSERT_IMP(a_valid_consistent, o_m_tvalid && (res.frame_valid || res.addressed),
        res.frame_valid && !res.overlong && res.frame_length >= MIN_FRAME,
        "inconsistent validity flags")

endmodule

bind modbus_rtu_frame_checker mrfc_checker u_mrfc_checker (.*);
